FILE: design/qph_pkg.sv
// Shared types, field widths and codes for the quadratic probe hash table.
package qph_pkg;

    localparam int ACT_W           = 2;
    localparam int KEY_W           = 31;
    localparam int VAL_W           = 32;
    localparam int STAT_W          = 3;
    localparam int SLOT_W          = 10;
    localparam int CFG_W           = 11;
    localparam int ENTRY_W         = 1 + KEY_W + VAL_W;
    localparam int DIV_CNT_W       = $clog2(KEY_W + 1);
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    // word index of the table size register (byte address 0)
    localparam logic [APB_ADDR_W-3:0] REG_TABLE_SIZE = 1'b0;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STAT_W-1:0] ST_MISS     = 3'd3;
    localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic probe_init;
        logic rd;
        logic advance;
        logic finish;
        logic skip;
    } qph_cmd_t;

    typedef struct packed {
        logic div_done;
        logic act_invalid;
        logic clr_last;
        logic stop;
    } qph_stat_t;

endpackage

FILE: design/qph_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qph_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/qph_div.sv
// Bit-serial restoring remainder unit: key modulo live table size.
module qph_div #(
    parameter int IDX_W = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [qph_pkg::KEY_W-1:0] key,
    input  logic [IDX_W:0]         n,
    output logic                   done,
    output logic [IDX_W-1:0]       rem
);

    import qph_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [KEY_W-1:0]     key_sh_reg;
    logic [IDX_W-1:0]     rem_reg;
    logic [IDX_W:0]       trial;
    logic [IDX_W:0]       trial_red;

    assign trial     = {rem_reg, key_sh_reg[KEY_W-1]};
    assign trial_red = (trial >= n) ? (trial - n) : trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(KEY_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_sh_reg <= key;
            rem_reg    <= '0;
        end
        else if (cnt_reg != '0)
        begin
            key_sh_reg <= {key_sh_reg[KEY_W-2:0], 1'b0};
            rem_reg    <= IDX_W'(trial_red);
        end
    end

    assign done = (cnt_reg == '0);
    assign rem  = rem_reg;

endmodule

FILE: design/qph_datapath.sv
// Datapath: request registers, probe index arithmetic, slot store and result registers.
module qph_datapath #(
    parameter int TABLE_DEPTH = qph_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  qph_pkg::qph_cmd_t          cmd,
    output qph_pkg::qph_stat_t         stat,
    input  logic [qph_pkg::CFG_W-1:0]  table_size,
    input  logic [qph_pkg::ACT_W-1:0]  action,
    input  logic [qph_pkg::KEY_W-1:0]  key,
    input  logic [qph_pkg::VAL_W-1:0]  value,
    output logic                       done,
    output logic [qph_pkg::STAT_W-1:0] status,
    output logic [qph_pkg::VAL_W-1:0]  found_value,
    output logic [qph_pkg::SLOT_W-1:0] slot
);

    import qph_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int SW = IW + 1;

    logic [ACT_W-1:0]   act_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [SW-1:0]      n_reg;
    logic [IW-1:0]      home_reg;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      sq_reg;
    logic [IW-1:0]      odd_reg;
    logic [IW-1:0]      clr_cnt_reg;
    logic               done_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [VAL_W-1:0]   fval_reg;
    logic [SLOT_W-1:0]  slot_reg;

    logic [31:0]        size_ext;
    logic [31:0]        live_ext;
    logic [SW-1:0]      n_next;
    logic               div_done;
    logic [IW-1:0]      div_rem;
    logic [SW-1:0]      sq_sum;
    logic [SW-1:0]      odd_sum;
    logic [SW-1:0]      idx_sum;
    logic [IW-1:0]      sq_next;
    logic [IW-1:0]      odd_next;
    logic [IW-1:0]      idx_cand;
    logic [ENTRY_W-1:0] rd_data;
    logic               rd_used;
    logic [KEY_W-1:0]   rd_key;
    logic [VAL_W-1:0]   rd_val;
    logic               hit;
    logic               empty;
    logic               wrap;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [STAT_W-1:0]  status_next;
    logic [VAL_W-1:0]   fval_next;
    logic [SLOT_W-1:0]  slot_next;
    logic               wr_entry;

    // live size: zero acts as one, clamp to depth
    always_comb
    begin
        size_ext = 32'(table_size);
        if (size_ext == 32'd0)
        begin
            live_ext = 32'd1;
        end
        else if (size_ext > 32'(TABLE_DEPTH))
        begin
            live_ext = 32'(TABLE_DEPTH);
        end
        else
        begin
            live_ext = size_ext;
        end
        n_next = SW'(live_ext);
    end

    qph_div #(
        .IDX_W (IW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .key   (key),
        .n     (n_reg),
        .done  (div_done),
        .rem   (div_rem)
    );

    // incremental i*i mod n: sq += odd, odd += 2, each reduced once
    always_comb
    begin
        sq_sum  = SW'(sq_reg) + SW'(odd_reg);
        sq_next = (sq_sum >= n_reg) ? IW'(sq_sum - n_reg) : IW'(sq_sum);
        odd_sum = SW'(odd_reg) + SW'(2);
        if (n_reg == SW'(1))
        begin
            odd_next = '0;
        end
        else
        begin
            odd_next = (odd_sum >= n_reg) ? IW'(odd_sum - n_reg) : IW'(odd_sum);
        end
        idx_sum  = SW'(home_reg) + SW'(sq_reg);
        idx_cand = (idx_sum >= n_reg) ? IW'(idx_sum - n_reg) : IW'(idx_sum);
    end

    assign rd_used = rd_data[ENTRY_W-1];
    assign rd_key  = rd_data[ENTRY_W-2:VAL_W];
    assign rd_val  = rd_data[VAL_W-1:0];
    assign hit     = rd_used && (rd_key == key_reg);
    assign empty   = !rd_used;
    assign wrap    = (idx_cand == home_reg);

    assign stat.div_done    = div_done;
    assign stat.act_invalid = !(act_reg == ACT_INSERT || act_reg == ACT_SEARCH
                                || act_reg == ACT_REMOVE);
    assign stat.clr_last    = (clr_cnt_reg == IW'(TABLE_DEPTH - 1));
    assign stat.stop        = empty || hit || wrap;

    // outcome of the finished walk
    always_comb
    begin
        status_next = ST_MISS;
        fval_next   = '0;
        slot_next   = '0;
        wr_entry    = 1'b0;
        ram_wdata   = {1'b1, key_reg, val_reg};
        case (act_reg)
            ACT_INSERT:
            begin
                if (empty)
                begin
                    status_next = ST_INSERTED;
                    slot_next   = SLOT_W'(idx_reg);
                    wr_entry    = 1'b1;
                end
                else if (hit)
                begin
                    status_next = ST_UPDATED;
                    slot_next   = SLOT_W'(idx_reg);
                    wr_entry    = 1'b1;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            ACT_SEARCH:
            begin
                if (hit)
                begin
                    status_next = ST_FOUND;
                    fval_next   = rd_val;
                    slot_next   = SLOT_W'(idx_reg);
                end
            end
            ACT_REMOVE:
            begin
                if (hit)
                begin
                    status_next = ST_REMOVED;
                    slot_next   = SLOT_W'(idx_reg);
                    wr_entry    = 1'b1;
                    ram_wdata   = {1'b0, rd_key, rd_val};
                end
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.clr_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else
        begin
            ram_we    = cmd.finish && wr_entry;
            ram_waddr = idx_reg;
        end
    end

    qph_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.clr_wr ? '0 : ram_wdata),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            done_reg <= cmd.finish || cmd.skip;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            key_reg <= key;
            val_reg <= value;
            n_reg   <= n_next;
        end
        if (cmd.probe_init)
        begin
            home_reg <= div_rem;
            idx_reg  <= div_rem;
            sq_reg   <= '0;
            odd_reg  <= (n_reg == SW'(1)) ? IW'(0) : IW'(1);
        end
        else
        begin
            if (cmd.rd)
            begin
                sq_reg  <= sq_next;
                odd_reg <= odd_next;
            end
            if (cmd.advance)
            begin
                idx_reg <= idx_cand;
            end
        end
        if (cmd.finish)
        begin
            status_reg <= status_next;
            fval_reg   <= fval_next;
            slot_reg   <= slot_next;
        end
        else if (cmd.skip)
        begin
            status_reg <= ST_MISS;
            fval_reg   <= '0;
            slot_reg   <= '0;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign found_value = fval_reg;
    assign slot        = slot_reg;

endmodule

FILE: design/qph_ctrl.sv
// Controller state machine: clearing pass, remainder, probe read and check.
module qph_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  qph_pkg::qph_stat_t stat,
    output qph_pkg::qph_cmd_t  cmd,
    output logic               busy
);

    import qph_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CLEAR  = 5'b00010,
        S_DIVIDE = 5'b00100,
        S_READ   = 5'b01000,
        S_CHECK  = 5'b10000
    } qph_state_t;

    qph_state_t state_reg;
    qph_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                if (stat.act_invalid)
                begin
                    cmd.skip   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.div_done)
                begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.stop)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

FILE: design/quadratic_probe_hash_table_core.sv
// Top level: open-addressing hash table with quadratic probing and APB size register.
//
//  channel   | transfer condition            | payload
//  ----------+-------------------------------+--------------------------------
//  request   | start && !busy                | action, key, value
//  result    | done (one-cycle strobe)       | status, found_value, slot
//  config    | psel && penable && pwrite     | pwdata -> table_size (addr 0)
//
// The result transfer follows the request transfer after the bit-serial key remainder
// (31 shifts), then one RAM read and one compare per probe, then the result register.
// An unused action code is answered from the remainder state without any probe. The
// next request is taken in the result strobe cycle. After reset a clearing pass empties
// every slot of the RAM; busy stays high meanwhile. Results cannot be stalled by the
// receiver.
module quadratic_probe_hash_table_core #(
    parameter int TABLE_DEPTH = qph_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [qph_pkg::ACT_W-1:0]       action,
    input  logic [qph_pkg::KEY_W-1:0]       key,
    input  logic [qph_pkg::VAL_W-1:0]       value,
    output logic                            done,
    output logic [qph_pkg::STAT_W-1:0]      status,
    output logic [qph_pkg::VAL_W-1:0]       found_value,
    output logic [qph_pkg::SLOT_W-1:0]      slot,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qph_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [qph_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [qph_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    import qph_pkg::*;

    logic [CFG_W-1:0] size_reg;
    logic             size_sel;
    qph_cmd_t         cmd;
    qph_stat_t        stat;

    assign pready   = 1'b1;
    assign size_sel = (paddr[APB_ADDR_W-1:2] == REG_TABLE_SIZE);
    assign prdata   = size_sel ? APB_DATA_W'(size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready && size_sel)
        begin
            size_reg <= pwdata[CFG_W-1:0];
        end
    end

    qph_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    qph_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .table_size  (size_reg),
        .action      (action),
        .key         (key),
        .value       (value),
        .done        (done),
        .status      (status),
        .found_value (found_value),
        .slot        (slot)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= ST_FULL))
        else $error("result status out of range");

    a_fval_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_FOUND) |-> (found_value == '0))
        else $error("found_value nonzero without a hit");

    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_MISS || status == ST_FULL)) |-> (slot == '0))
        else $error("slot nonzero on miss or full");

endmodule

FILE: verif/quadratic_probe_hash_table_core_tb.sv
// Self-checking testbench for the quadratic probe hash table core.
module quadratic_probe_hash_table_core_tb;
    import qph_pkg::*;

    localparam int DEPTH      = TABLE_DEPTH_DEF;
    localparam int QUIET_MAX  = 12000;
    localparam int CALM_TAIL  = 150;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef enum logic [1:0] {OP_TABLE, OP_SIZE, OP_DRAIN} op_t;
    typedef enum {WALK_HIT, WALK_EMPTY, WALK_WRAP} walk_t;

    typedef struct packed {
        op_t              op;
        logic [ACT_W-1:0] act;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        logic [31:0]      sz;
    } table_req_t;

    typedef struct packed {
        logic [STAT_W-1:0] st;
        logic [VAL_W-1:0]  fv;
        logic [SLOT_W-1:0] sl;
    } table_rsp_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [ACT_W-1:0]       action = '0;
    logic [KEY_W-1:0]       key = '0;
    logic [VAL_W-1:0]       value = '0;
    logic                   done;
    logic [STAT_W-1:0]      status;
    logic [VAL_W-1:0]       found_value;
    logic [SLOT_W-1:0]      slot;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    table_req_t request_q[$];
    table_rsp_t pending_results[$];
    int         mismatches = 0;

    // shadow of the table
    bit               tbl_used[DEPTH];
    logic [KEY_W-1:0] tbl_key[DEPTH];
    logic [VAL_W-1:0] tbl_val[DEPTH];
    logic [CFG_W-1:0] size_reg = SIZE_RESET;

    quadratic_probe_hash_table_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .key         (key),
        .value       (value),
        .done        (done),
        .status      (status),
        .found_value (found_value),
        .slot        (slot),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned live_slots();
        int unsigned n;
        n = 32'(size_reg);
        if (n == 0)
            n = 1;
        if (n > DEPTH)
            n = DEPTH;
        return n;
    endfunction

    function automatic walk_t probe_walk(input logic [KEY_W-1:0] k, output int unsigned at);
        int unsigned n;
        int unsigned home;
        int unsigned idx;
        longint      i;
        n = live_slots();
        home = k % n;
        idx = home;
        i = 1;
        while (1)
        begin
            if (!tbl_used[idx])
            begin
                at = idx;
                return WALK_EMPTY;
            end
            if (tbl_key[idx] == k)
            begin
                at = idx;
                return WALK_HIT;
            end
            idx = int'((longint'(home) + (i * i) % longint'(n)) % longint'(n));
            i++;
            if (idx == home)
            begin
                at = 0;
                return WALK_WRAP;
            end
        end
    endfunction

    function automatic void apply_table_op(input logic [ACT_W-1:0] act,
                                           input logic [KEY_W-1:0] k,
                                           input logic [VAL_W-1:0] v);
        table_rsp_t  r;
        walk_t       w;
        int unsigned at;
        r.st = ST_MISS;
        r.fv = '0;
        r.sl = '0;
        if (act == ACT_INSERT || act == ACT_SEARCH || act == ACT_REMOVE)
        begin
            w = probe_walk(k, at);
            if (act == ACT_INSERT)
            begin
                if (w == WALK_HIT)
                begin
                    tbl_val[at] = v;
                    r.st = ST_UPDATED;
                    r.sl = at[SLOT_W-1:0];
                end
                else if (w == WALK_EMPTY)
                begin
                    tbl_used[at] = 1'b1;
                    tbl_key[at] = k;
                    tbl_val[at] = v;
                    r.st = ST_INSERTED;
                    r.sl = at[SLOT_W-1:0];
                end
                else
                    r.st = ST_FULL;
            end
            else if (act == ACT_SEARCH)
            begin
                if (w == WALK_HIT)
                begin
                    r.st = ST_FOUND;
                    r.fv = tbl_val[at];
                    r.sl = at[SLOT_W-1:0];
                end
            end
            else if (w == WALK_HIT)
            begin
                tbl_used[at] = 1'b0;
                r.st = ST_REMOVED;
                r.sl = at[SLOT_W-1:0];
            end
        end
        pending_results.push_back(r);
    endfunction

    function automatic void push_op(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k,
                                    input logic [VAL_W-1:0] v);
        table_req_t t;
        t.op = OP_TABLE;
        t.act = act;
        t.k = k;
        t.v = v;
        t.sz = '0;
        request_q.push_back(t);
    endfunction

    function automatic void push_size(input logic [31:0] sz);
        table_req_t t;
        t = '0;
        t.op = OP_SIZE;
        t.sz = sz;
        request_q.push_back(t);
    endfunction

    function automatic void push_drain();
        table_req_t t;
        t = '0;
        t.op = OP_DRAIN;
        request_q.push_back(t);
    endfunction

    // request and register driver
    int unsigned idle_left = 0;
    bit          idle_after_done = 1'b0;
    int unsigned calm_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic       nxt_start;
        table_req_t head;
        if (!rst_n)
        begin
            start <= 1'b0;
            action <= '0;
            key <= '0;
            value <= '0;
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= '0;
            pwdata <= '0;
        end
        else
        begin
            nxt_start = start;
            if (start && !busy)
            begin
                apply_table_op(action, key, value);
                nxt_start = 1'b0;
            end
            if (psel && penable && pwrite && pready)
            begin
                size_reg = pwdata[CFG_W-1:0];
                psel <= 1'b0;
                penable <= 1'b0;
                pwrite <= 1'b0;
            end
            else if (psel)
                penable <= 1'b1;
            else if (!nxt_start)
            begin
                if (idle_left > 0)
                begin
                    if (!idle_after_done || !busy)
                        idle_left--;
                end
                else if (request_q.size() > 0)
                begin
                    head = request_q[0];
                    case (head.op)
                        OP_TABLE:
                        begin
                            void'(request_q.pop_front());
                            nxt_start = 1'b1;
                            action <= head.act;
                            key <= head.k;
                            value <= head.v;
                            if (request_q.size() > CALM_TAIL)
                            begin
                                if (calm_left > 0)
                                    calm_left--;
                                else if ($urandom_range(0, 3) == 0)
                                begin
                                    idle_left = $urandom_range(1, 18);
                                    idle_after_done = 1'($urandom_range(0, 1));
                                    if ($urandom_range(0, 4) == 0)
                                        calm_left = $urandom_range(20, 60);
                                end
                            end
                        end
                        OP_SIZE:
                        begin
                            if (pending_results.size() == 0 && !done && !busy)
                            begin
                                void'(request_q.pop_front());
                                psel <= 1'b1;
                                pwrite <= 1'b1;
                                paddr <= {REG_TABLE_SIZE, 2'b00};
                                pwdata <= head.sz;
                            end
                        end
                        default:
                        begin
                            if (pending_results.size() == 0 && !done)
                                void'(request_q.pop_front());
                        end
                    endcase
                end
            end
            start <= nxt_start;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        table_rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result expected none actual status %0d found_value %0h slot %0d",
                         $time, status, found_value, slot);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d", $time, want.st, status);
                end
                if (found_value !== want.fv)
                begin
                    mismatches++;
                    $display("%0t: found_value expected %0h actual %0h",
                             $time, want.fv, found_value);
                end
                if (slot !== want.sl)
                begin
                    mismatches++;
                    $display("%0t: slot expected %0d actual %0d", $time, want.sl, slot);
                end
            end
        end
    end

    // watchdog on transfer activity
    int unsigned quiet = 0;

    always @(posedge clk)
    begin
        if (done || (start && !busy) || (psel && penable && pwrite))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_MAX)
        begin
            $display("%0t: timeout, no transfer for %0d cycles", $time, quiet);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int unsigned      sizes[14];
        logic [KEY_W-1:0] key_pool[$];
        logic [KEY_W-1:0] k;
        int unsigned      n;
        int unsigned      psz;
        int unsigned      r;
        logic [ACT_W-1:0] a;

        sizes = '{3, 8, 1, 16, 7, 2, 0, 64, 13, 1024, 5, 31, 2047, 4};
        sizes[7] = $urandom_range(33, 1023);

        // empty table at reset size, then collisions on a size of 8
        push_op(ACT_SEARCH, 31'd0, 32'h0);
        push_size(32'd8);
        push_op(ACT_INSERT, 31'd0, 32'h0000_0000);
        push_op(ACT_INSERT, 31'd8, 32'hFFFF_FFFF);
        push_op(ACT_INSERT, 31'd16, 32'h5A5A_A5A5);
        push_op(ACT_SEARCH, 31'd8, 32'h0);
        push_op(ACT_INSERT, 31'd8, 32'h1234_5678);
        push_op(ACT_SEARCH, 31'd8, 32'hFFFF_FFFF);
        push_op(ACT_REMOVE, 31'd0, 32'h0);
        // no tombstone: the chain through home is broken
        push_op(ACT_SEARCH, 31'd8, 32'h0);
        push_op(ACT_REMOVE, 31'd0, 32'h0);
        push_op(ACT_UNUSED, 31'd16, 32'hFFFF_FFFF);
        push_op(ACT_SEARCH, 31'd16, 32'h0);
        push_op(ACT_INSERT, 31'h7FFF_FFFF, 32'h8000_0001);
        // zero size acts as one slot
        push_size(32'd0);
        push_op(ACT_INSERT, 31'd5, 32'hCAFE_F00D);
        push_op(ACT_INSERT, 31'd6, 32'h1);
        push_op(ACT_SEARCH, 31'd6, 32'h0);
        // oversize clamps to full depth, old entries stay in place
        push_size(32'd2047);
        push_op(ACT_SEARCH, 31'd5, 32'h0);
        push_op(ACT_INSERT, 31'h7FFF_FFFF, 32'hDEAD_BEEF);
        push_op(ACT_SEARCH, 31'h7FFF_FFFF, 32'h0);
        push_op(ACT_REMOVE, 31'h7FFF_FFFF, 32'h0);
        push_size(32'd1024);
        push_op(ACT_SEARCH, 31'd1023, 32'h0);

        for (int p = 0; p < 14; p++)
        begin
            push_size(sizes[p]);
            n = sizes[p];
            if (n == 0)
                n = 1;
            if (n > DEPTH)
                n = DEPTH;
            psz = (2 * n + 2 < 48) ? 2 * n + 2 : 48;
            key_pool.delete();
            for (int j = 0; j < psz; j++)
                key_pool.push_back(KEY_W'($urandom));
            for (int j = 0; j < 79; j++)
            begin
                if (p == 3 && j == 40)
                    push_drain();
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[$urandom_range(0, psz - 1)];
                else
                    k = KEY_W'($urandom);
                r = $urandom_range(0, 99);
                if (r < 40)
                    a = ACT_INSERT;
                else if (r < 75)
                    a = ACT_SEARCH;
                else if (r < 95)
                    a = ACT_REMOVE;
                else
                    a = ACT_UNUSED;
                push_op(a, k, $urandom);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || pending_results.size() != 0 || start || psel)
            @(negedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
